/* sv/stxrx_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the frame receiver.
package stxrx_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH   = 2'd2;

    localparam logic [7:0]  START_MARKER_RESET = 8'h02;
    localparam logic [7:0]  END_MARKER_RESET   = 8'h03;
    localparam logic [15:0] MAX_LENGTH_RESET   = 16'd132;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        VD_CRC_GOOD,
        VD_CRC_BAD,
        VD_END_WRONG,
        VD_LEN_TOO_LARGE
    } verdict_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
        verdict_t    verdict;
    } result_t;

    // MSB-first CRC-16, one byte folded in eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* sv/stxrx_cfg_regs.sv */
// Configuration registers: start marker, end marker and payload length limit.
module stxrx_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stxrx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [stxrx_pkg::CFG_DATA_W-1:0]   cfg_data,
    output stxrx_pkg::cfg_t                    cfg
);
    import stxrx_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker     <= START_MARKER_RESET;
            cfg_reg.end_marker       <= END_MARKER_RESET;
            cfg_reg.max_frame_length <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker     <= cfg_data[7:0];
                REG_END_MARKER:   cfg_reg.end_marker       <= cfg_data[7:0];
                REG_MAX_LENGTH:   cfg_reg.max_frame_length <= cfg_data[15:0];
                default:          ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/stxrx_deframer.sv */
// Deframer: input byte register, frame state machine with CRC, result register.
module stxrx_deframer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stxrx_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stxrx_pkg::result_t   result
);
    import stxrx_pkg::*;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    phase_t      phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    // result stage
    logic    out_valid_reg;
    result_t result_reg;

    logic    res_valid;
    result_t res;
    logic    advance;
    logic [7:0]  b;
    logic [15:0] crc_fed;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign b         = in_byte_reg;
    assign crc_fed   = crc16_byte(crc_reg, b);
    assign len_full  = {length_reg[15:8], b};
    assign count_inc = count_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            command_reg <= 8'h00;
            length_reg  <= 16'h0000;
            count_reg   <= 16'h0000;
            crc_reg     <= CRC_INIT;
            rx_crc_reg  <= 16'h0000;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        rx_crc_next  = rx_crc_reg;
        res_valid    = 1'b0;
        res.result_kind   = KIND_PAYLOAD;
        res.payload_byte  = 8'h00;
        res.byte_index    = 16'h0000;
        res.frame_command = command_reg;
        res.frame_length  = length_reg;
        res.verdict       = VD_CRC_GOOD;
        case (phase_reg)
            PH_IDLE:
            begin
                if (b == cfg.start_marker)
                begin
                    command_next = 8'h00;
                    length_next  = 16'h0000;
                    count_next   = 16'h0000;
                    crc_next     = CRC_INIT;
                    phase_next   = PH_CMD;
                end
            end
            PH_CMD:
            begin
                command_next = b;
                crc_next     = crc_fed;
                phase_next   = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {b, 8'h00};
                crc_next    = crc_fed;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = len_full;
                crc_next    = crc_fed;
                count_next  = 16'h0000;
                res.frame_length = len_full;
                if (len_full == 16'h0000)
                    phase_next = PH_CRC_HI;
                else if (len_full > cfg.max_frame_length)
                begin
                    phase_next      = PH_IDLE;
                    res_valid       = 1'b1;
                    res.result_kind = KIND_VERDICT;
                    res.verdict     = VD_LEN_TOO_LARGE;
                end
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                res_valid        = 1'b1;
                res.payload_byte = b;
                res.byte_index   = count_reg;
                crc_next         = crc_fed;
                count_next       = count_inc;
                if (count_inc >= length_reg)
                    phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                rx_crc_next = {b, 8'h00};
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                rx_crc_next = {rx_crc_reg[15:8], b};
                phase_next  = PH_END;
            end
            PH_END:
            begin
                phase_next      = PH_IDLE;
                res_valid       = 1'b1;
                res.result_kind = KIND_VERDICT;
                if (b != cfg.end_marker)
                    res.verdict = VD_END_WRONG;
                else if (crc_reg == rx_crc_reg)
                    res.verdict = VD_CRC_GOOD;
                else
                    res.verdict = VD_CRC_BAD;
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            result_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // a payload transfer never carries a verdict
    a_payload_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.result_kind == KIND_PAYLOAD)
            |-> result_reg.verdict == VD_CRC_GOOD)
        else $error("payload result with nonzero verdict");

    // verdict results carry zero data and index
    a_verdict_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.result_kind == KIND_VERDICT)
            |-> (result_reg.payload_byte == 8'h00 && result_reg.byte_index == 16'h0000))
        else $error("verdict result with payload data");

    // payload index stays inside the declared length
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.result_kind == KIND_PAYLOAD)
            |-> result_reg.byte_index < result_reg.frame_length)
        else $error("payload index beyond frame length");

    // bytes seen outside a frame produce nothing
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_IDLE) |=> !out_valid_reg)
        else $error("result produced outside a frame");

    // every verdict returns the receiver to hunting for a start marker
    a_verdict_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.result_kind == KIND_VERDICT) |=> phase_reg == PH_IDLE)
        else $error("phase not idle after verdict");

endmodule

/* sv/stx_etx_frame_receiver_crc16.sv */
// Top level of the framed serial receiver with CRC-16 check.
//
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) takes one received serial byte
//   per transfer. Output channel (out_valid/out_ready plus result fields)
//   gives at most one result per byte: a payload byte with its index, or a
//   frame verdict (0 crc good, 1 crc bad, 2 end marker wrong, 3 length too
//   large). Consumers drop payload of any frame whose verdict is not good.
//   Configuration (cfg_we/cfg_index/cfg_data) sets start marker, end marker
//   and payload length limit; write only while no byte is in flight.
// Timing:
//   A byte lands in the input register on its transfer and is processed when
//   the result register is free or being read; its result is then registered.
//   Throughput is one byte per cycle unless the output stalls: the CRC byte
//   update and the frame state machine sit in a single stage between registers.
// Reset: the receiver hunts for a start marker, registers take defaults
//   (0x02, 0x03, 132). A stalled output holds its result; input keeps
//   flowing until both the input and result registers are full.
module stx_etx_frame_receiver_crc16 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [stxrx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [stxrx_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               result_kind,
    output logic [7:0]                         payload_byte,
    output logic [15:0]                        byte_index,
    output logic [7:0]                         frame_command,
    output logic [15:0]                        frame_length,
    output logic [1:0]                         verdict
);
    import stxrx_pkg::*;

    cfg_t    cfg;
    result_t result;

    stxrx_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stxrx_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign result_kind   = result.result_kind;
    assign payload_byte  = result.payload_byte;
    assign byte_index    = result.byte_index;
    assign frame_command = result.frame_command;
    assign frame_length  = result.frame_length;
    assign verdict       = result.verdict;

endmodule

/* sim/stx_etx_frame_receiver_crc16_tb.sv */
// Self-checking testbench for the framed serial receiver: directed frames, then random traffic.
module stx_etx_frame_receiver_crc16_tb;

    import stxrx_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_SHOWN = 10;

    typedef enum logic [1:0] {
        PIN_OPEN,
        PIN_SILENT,
        PIN_VERDICT
    } pin_t;

    typedef struct packed {
        logic [7:0] data;
        pin_t       pin;
        result_t    want;
    } stim_t;

    typedef struct packed {
        logic        has_noise;
        logic [7:0]  noise;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [1:0]  pay_n;
        logic [15:0] pay;
        logic [15:0] crc_flip;
        logic [7:0]  tail;
        verdict_t    pin_v;
    } frame_row_t;

    typedef logic [7:0] byte_q_t[$];

    // Directed frames under the reset register values
    localparam frame_row_t FRAME_ROWS [4] = '{
        // zero length, all-zero command, good CRC
        '{1'b1, 8'h55, 8'h00, 16'h0000, 2'd0, 16'h0000, 16'h0000, 8'h03, VD_CRC_GOOD},
        // largest declared length aborts right after the length
        '{1'b1, 8'hFF, 8'hFF, 16'hFFFF, 2'd0, 16'h0000, 16'h0000, 8'h03, VD_LEN_TOO_LARGE},
        // start marker and 0xFF inside the payload, CRC corrupted
        '{1'b0, 8'h00, 8'h5A, 16'h0002, 2'd2, 16'h02FF, 16'h0001, 8'h03, VD_CRC_BAD},
        // good CRC but wrong end marker
        '{1'b0, 8'h00, 8'h81, 16'h0001, 2'd1, 16'h0000, 16'h0000, 8'h00, VD_END_WRONG}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   result_kind;
    logic [7:0]             payload_byte;
    logic [15:0]            byte_index;
    logic [7:0]             frame_command;
    logic [15:0]            frame_length;
    logic [1:0]             verdict;

    stim_t   cur_item = '0;
    stim_t   byte_feed[$];
    result_t pending_results[$];

    // predictor state and register copy
    phase_t      frame_ph = PH_IDLE;
    logic [7:0]  cmd_reg = 8'h00;
    logic [15:0] len_reg = 16'h0000;
    logic [15:0] pay_cnt = 16'h0000;
    logic [15:0] crc_run = CRC_INIT;
    logic [15:0] crc_rcv = 16'h0000;
    logic [7:0]  cfg_start = START_MARKER_RESET;
    logic [7:0]  cfg_end = END_MARKER_RESET;
    logic [15:0] cfg_max = MAX_LENGTH_RESET;

    bit gaps_on = 1'b1;
    bit hold_armed = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    int      errors = 0;
    int      bytes_in = 0;
    int      payload_out = 0;
    int      verdict_out [4] = '{0, 0, 0, 0};
    int      settings_n = 0;
    bit      pred_made;
    result_t pred_res;
    result_t seen;
    result_t want;

    stx_etx_frame_receiver_crc16 dut (
        .clk,
        .rst_n,
        .cfg_we,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_ready,
        .rx_byte,
        .out_valid,
        .out_ready,
        .result_kind,
        .payload_byte,
        .byte_index,
        .frame_command,
        .frame_length,
        .verdict
    );

    always #5 clk = ~clk;

    // bit-serial form of the CCITT update, MSB of the byte first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic result_t make_verdict(input verdict_t v, input logic [7:0] cmd,
                                             input logic [15:0] len);
        result_t r;
        r = '0;
        r.result_kind = KIND_VERDICT;
        r.frame_command = cmd;
        r.frame_length = len;
        r.verdict = v;
        return r;
    endfunction

    function automatic stim_t open_item(input logic [7:0] b);
        stim_t s;
        s = '0;
        s.data = b;
        s.pin = PIN_OPEN;
        return s;
    endfunction

    // one received byte through the deframer; at most one result
    task automatic deframe_byte(input logic [7:0] b, output bit made, output result_t res);
        made = 1'b0;
        res = '0;
        case (frame_ph)
            PH_IDLE:
            begin
                if (b == cfg_start)
                begin
                    cmd_reg = 8'h00;
                    len_reg = 16'h0000;
                    pay_cnt = 16'h0000;
                    crc_run = CRC_INIT;
                    frame_ph = PH_CMD;
                end
            end
            PH_CMD:
            begin
                cmd_reg = b;
                crc_run = crc_fold(crc_run, b);
                frame_ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_reg = {b, 8'h00};
                crc_run = crc_fold(crc_run, b);
                frame_ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_reg[7:0] = b;
                crc_run = crc_fold(crc_run, b);
                pay_cnt = 16'h0000;
                if (len_reg == 16'h0000)
                    frame_ph = PH_CRC_HI;
                else if (len_reg > cfg_max)
                begin
                    frame_ph = PH_IDLE;
                    made = 1'b1;
                    res = make_verdict(VD_LEN_TOO_LARGE, cmd_reg, len_reg);
                end
                else
                    frame_ph = PH_DATA;
            end
            PH_DATA:
            begin
                made = 1'b1;
                res.result_kind = KIND_PAYLOAD;
                res.payload_byte = b;
                res.byte_index = pay_cnt;
                res.frame_command = cmd_reg;
                res.frame_length = len_reg;
                res.verdict = VD_CRC_GOOD;
                crc_run = crc_fold(crc_run, b);
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt >= len_reg)
                    frame_ph = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                crc_rcv = {b, 8'h00};
                frame_ph = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                crc_rcv[7:0] = b;
                frame_ph = PH_END;
            end
            default:
            begin
                made = 1'b1;
                if (b != cfg_end)
                    res = make_verdict(VD_END_WRONG, cmd_reg, len_reg);
                else if (crc_run == crc_rcv)
                    res = make_verdict(VD_CRC_GOOD, cmd_reg, len_reg);
                else
                    res = make_verdict(VD_CRC_BAD, cmd_reg, len_reg);
                frame_ph = PH_IDLE;
            end
        endcase
    endtask

    // Builds one frame onto the feed; cut >= 0 keeps only that many bytes
    task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] len, input byte_q_t pay,
                               input logic [15:0] crc_flip, input logic [7:0] tail,
                               input bit pinned, input verdict_t pin_v, input int cut);
        stim_t       fr[$];
        logic [15:0] crc;
        fr.push_back(open_item(cfg_start));
        fr.push_back(open_item(cmd));
        fr.push_back(open_item(len[15:8]));
        fr.push_back(open_item(len[7:0]));
        crc = crc_fold(crc_fold(crc_fold(CRC_INIT, cmd), len[15:8]), len[7:0]);
        if (len == 16'h0000 || len <= cfg_max)
        begin
            foreach (pay[i])
            begin
                fr.push_back(open_item(pay[i]));
                crc = crc_fold(crc, pay[i]);
            end
            crc = crc ^ crc_flip;
            fr.push_back(open_item(crc[15:8]));
            fr.push_back(open_item(crc[7:0]));
            fr.push_back(open_item(tail));
        end
        // the last byte built is the one that carries the verdict
        if (pinned)
        begin
            fr[$].pin = PIN_VERDICT;
            fr[$].want = make_verdict(pin_v, cmd, len);
        end
        foreach (fr[i])
            if (cut < 0 || i < cut)
                byte_feed.push_back(fr[i]);
    endtask

    // Mostly well-formed frames with random content; some corrupted, cut short or too long
    task automatic queue_traffic(input int target);
        byte_q_t     pay;
        int          made_n;
        int          base;
        int          k;
        int          cut;
        logic [15:0] len;
        logic [15:0] flip;
        logic [7:0]  nb;
        logic [7:0]  tail;
        made_n = 0;
        while (made_n < target)
        begin
            repeat ($urandom_range(0, 2))
            begin
                nb = 8'($urandom);
                if (nb == cfg_start)
                    nb = nb ^ 8'h01;
                byte_feed.push_back(open_item(nb));
            end
            k = $urandom_range(0, 99);
            if (k < 10)
                len = 16'h0000;
            else if (k < 22 && cfg_max != 16'hFFFF)
                len = 16'($urandom_range(32'(cfg_max) + 1, 65535));
            else if (k < 24)
                len = 16'($urandom_range(1, 200));
            else
                len = 16'($urandom_range(1, 8));
            pay = {};
            if (len <= cfg_max)
                repeat (len)
                    pay.push_back(8'($urandom));
            flip = ($urandom_range(0, 99) < 8) ? 16'(1 << $urandom_range(0, 15)) : 16'h0000;
            tail = ($urandom_range(0, 99) < 8) ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end;
            cut = ($urandom_range(0, 99) < 5) ? int'($urandom_range(1, 6)) : -1;
            base = byte_feed.size();
            queue_frame(8'($urandom), len, pay, flip, tail, 1'b0, VD_CRC_GOOD, cut);
            made_n += byte_feed.size() - base;
        end
    endtask

    task automatic send_item(input stim_t s);
        while (gaps_on && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= s.data;
        cur_item <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic run_feed();
        while (byte_feed.size() != 0)
            send_item(byte_feed.pop_front());
        in_valid <= 1'b0;
    endtask

    // wait for every expected result, then idle so bytes that give none pass through
    task automatic drain();
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_START_MARKER: cfg_start = val[7:0];
            REG_END_MARKER:   cfg_end = val[7:0];
            REG_MAX_LENGTH:   cfg_max = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] s, input logic [7:0] e, input logic [15:0] m,
                                input bit stray);
        write_reg(REG_START_MARKER, {8'($urandom), s});
        write_reg(REG_END_MARKER, {8'($urandom), e});
        write_reg(REG_MAX_LENGTH, m);
        if (stray)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        settings_n++;
    endtask

    // receiver side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_armed && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = 80;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                bytes_in++;
                deframe_byte(cur_item.data, pred_made, pred_res);
                case (cur_item.pin)
                    PIN_OPEN:    if (pred_made) pending_results.push_back(pred_res);
                    PIN_VERDICT: pending_results.push_back(cur_item.want);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                seen.result_kind = result_kind;
                seen.payload_byte = payload_byte;
                seen.byte_index = byte_index;
                seen.frame_command = frame_command;
                seen.frame_length = frame_length;
                seen.verdict = verdict_t'(verdict);
                if (seen.result_kind == KIND_PAYLOAD)
                    payload_out++;
                else
                    verdict_out[seen.verdict]++;
                if (pending_results.size() == 0)
                begin
                    if (errors < MAX_SHOWN)
                        $display("extra: kind %0d data %02h idx %0d cmd %02h len %0d vd %0d",
                                 seen.result_kind, seen.payload_byte, seen.byte_index,
                                 seen.frame_command, seen.frame_length, seen.verdict);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.result_kind !== want.result_kind
                        || seen.payload_byte !== want.payload_byte
                        || seen.byte_index !== want.byte_index
                        || seen.frame_command !== want.frame_command
                        || seen.frame_length !== want.frame_length
                        || seen.verdict !== want.verdict)
                    begin
                        if (errors < MAX_SHOWN)
                        begin
                            $display("got : kind %0d data %02h idx %0d cmd %02h len %0d vd %0d",
                                     seen.result_kind, seen.payload_byte, seen.byte_index,
                                     seen.frame_command, seen.frame_length, seen.verdict);
                            $display("want: kind %0d data %02h idx %0d cmd %02h len %0d vd %0d",
                                     want.result_kind, want.payload_byte, want.byte_index,
                                     want.frame_command, want.frame_length, want.verdict);
                        end
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        byte_q_t pay;
        stim_t   nz;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (FRAME_ROWS[r])
        begin
            pay = {};
            for (int i = FRAME_ROWS[r].pay_n - 1; i >= 0; i--)
                pay.push_back(FRAME_ROWS[r].pay[i*8 +: 8]);
            if (FRAME_ROWS[r].has_noise)
            begin
                nz = '0;
                nz.data = FRAME_ROWS[r].noise;
                nz.pin = PIN_SILENT;
                byte_feed.push_back(nz);
            end
            queue_frame(FRAME_ROWS[r].cmd, FRAME_ROWS[r].len, pay, FRAME_ROWS[r].crc_flip,
                        FRAME_ROWS[r].tail, 1'b1, FRAME_ROWS[r].pin_v, -1);
        end
        run_feed();
        drain();

        program_regs(START_MARKER_RESET, END_MARKER_RESET, MAX_LENGTH_RESET, 1'b0);
        queue_traffic(150);
        run_feed();
        drain();

        // zero limit: only empty frames get through
        program_regs(8'h00, 8'hFF, 16'h0000, 1'b0);
        queue_traffic(100);
        run_feed();
        drain();

        // widest limit, long receiver hold-off backs up the input
        program_regs(8'hFF, 8'h00, 16'hFFFF, 1'b0);
        hold_armed = 1'b1;
        queue_traffic(150);
        run_feed();
        drain();

        // no idling on either side; finish with a dangling frame header
        gaps_on = 1'b0;
        program_regs(8'h7E, 8'h81, 16'd5, 1'b0);
        queue_traffic(200);
        byte_feed.push_back(open_item(cfg_start));
        byte_feed.push_back(open_item(8'($urandom)));
        byte_feed.push_back(open_item(8'h00));
        run_feed();
        drain();
        gaps_on = 1'b1;

        // rewrite registers in the middle of that frame, plus a write to the unused index
        program_regs(8'($urandom), 8'($urandom), 16'd3, 1'b1);
        queue_traffic(150);
        run_feed();
        drain();

        program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(0, 400)), 1'b0);
        queue_traffic(150);
        run_feed();
        drain();

        $display("Covered %0d bytes under %0d register settings: %0d payload results",
                 bytes_in, settings_n + 1, payload_out);
        $display("verdicts: crc good %0d, crc bad %0d, end marker wrong %0d, too long %0d",
                 verdict_out[VD_CRC_GOOD], verdict_out[VD_CRC_BAD],
                 verdict_out[VD_END_WRONG], verdict_out[VD_LEN_TOO_LARGE]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
